[sv/clt_pkg.sv]
// ---------------------------------------------------------------------------
// clt_pkg: shared types and constants
// Field widths, register indexes, phase codes and the lane control group of
// the calibrated leak threshold monitor.
// ---------------------------------------------------------------------------
`default_nettype none
package clt_pkg;
  localparam int SAMPLE_W = 24;
  localparam int LIMIT_W  = 28;
  localparam int MARGIN_W = 20;
  localparam int MULT_W   = 4;
  localparam int CCOUNT_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam int PHASE_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_MULT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V_MARGIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_R_MARGIN  = 2'd3;

  localparam logic [CCOUNT_W-1:0] CAL_COUNT_RST = 5'd15;
  localparam logic [MULT_W-1:0]   DEV_MULT_RST  = 4'd4;
  localparam logic [MARGIN_W-1:0] V_MARGIN_RST  = 20'd512;
  localparam logic [MARGIN_W-1:0] R_MARGIN_RST  = 20'd128;

  localparam logic [PHASE_W-1:0] PHASE_CAL   = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_WATCH = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_HALT  = 2'd2;

  // Deviation used when only one pair calibrates, in 24.8.
  localparam logic [31:0] SINGLE_STDEV_FX = 32'd5000 << 8;
  localparam int MIN_FOR_DEV = 2;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};

  typedef struct packed {
    logic wr;
    logic start;
  } clt_ctrl_t;
endpackage
`default_nettype wire

[sv/clt_lane.sv]
// ---------------------------------------------------------------------------
// clt_lane: one channel of the threshold calculation
// Stores calibration samples, tracks the peak and running sum, then derives
// mean, sample deviation and limit with a shared serial divider and a serial
// square root.
// ---------------------------------------------------------------------------
`default_nettype none
module clt_lane import clt_pkg::*; #(
  parameter int MAX_SAMPLES = 16,
  localparam int CW = $clog2(MAX_SAMPLES + 1),
  localparam int AW = $clog2(MAX_SAMPLES)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire clt_ctrl_t           ctrl,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic [AW-1:0]       wr_idx,
  input  wire logic [CW-1:0]       n,
  input  wire logic [MULT_W-1:0]   mult,
  input  wire logic [MARGIN_W-1:0] margin,
  output logic                     idle,
  output logic [LIMIT_W-1:0]       limit
);
  localparam int SW = SAMPLE_W + CW;
  localparam logic [2:0] L_IDLE = 3'd0, L_LOAD = 3'd1, L_MEAN = 3'd2, L_WALK = 3'd3,
                         L_VAR = 3'd4, L_SQRT = 3'd5, L_LIM = 3'd6;

  logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [2:0]  state_r;
  logic [SW-1:0] sum_r;
  logic [SAMPLE_W-1:0] peak_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [5:0]  step_r;
  logic [63:0] dq_r, dq_nxt;
  logic [CW-1:0] rem_r, rem_nxt, div_r;
  logic [CW:0] rem_sh;
  logic        div_ge;
  logic [31:0] mean_r, stdev_r;
  logic [CW-1:0] issue_r;
  logic        v1_r, v2_r, v3_r;
  logic [31:0] d_r, s_fx;
  logic [63:0] sq_r, acc_r;
  logic [63:0] sv_r;
  logic [31:0] root_r, root_nxt;
  logic [33:0] srem_r, srem_nxt, srem_sh, trial;
  logic        issuing;
  logic [36:0] lim_sum;

  // One restoring division step.
  always_comb begin
    rem_sh = {rem_r, dq_r[63]};
    div_ge = rem_sh >= {1'b0, div_r};
    rem_nxt = div_ge ? CW'(rem_sh - {1'b0, div_r}) : rem_sh[CW-1:0];
    dq_nxt = {dq_r[62:0], div_ge};
  end

  // One square root digit.
  always_comb begin
    srem_sh = {srem_r[31:0], sv_r[63:62]};
    trial = {root_r, 2'b01};
    if (srem_sh >= trial) begin
      srem_nxt = srem_sh - trial;
      root_nxt = {root_r[30:0], 1'b1};
    end else begin
      srem_nxt = srem_sh;
      root_nxt = {root_r[30:0], 1'b0};
    end
  end

  assign issuing = (state_r == L_WALK) && (issue_r < n);
  assign s_fx = {rd_data_r, 8'b0};
  assign lim_sum = {5'b0, peak_r, 8'b0} + {1'b0, 32'(mult) * 36'(stdev_r)}
                 + {9'b0, margin, 8'b0};

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[wr_idx] <= sample;
    end
    if (issuing) begin
      rd_data_r <= mem[issue_r[AW-1:0]];
    end
    d_r <= (s_fx >= mean_r) ? s_fx - mean_r : mean_r - s_fx;
    sq_r <= 64'(d_r) * 64'(d_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      sum_r   <= '0;
      peak_r  <= '0;
      limit_r <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
    end else begin
      if (ctrl.wr) begin
        sum_r <= sum_r + SW'(sample);
        if (sample > peak_r) peak_r <= sample;
      end
      v1_r <= issuing;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (v3_r) acc_r <= acc_r + {8'b0, sq_r[63:8]};
      unique case (state_r)
        L_IDLE: begin
          if (ctrl.start) state_r <= L_LOAD;
        end
        L_LOAD: begin
          if (32'(n) < MIN_FOR_DEV) begin
            stdev_r <= SINGLE_STDEV_FX;
            state_r <= L_LIM;
          end else begin
            dq_r    <= 64'({sum_r, 8'b0});
            rem_r   <= '0;
            div_r   <= n;
            step_r  <= '0;
            state_r <= L_MEAN;
          end
        end
        L_MEAN: begin
          dq_r   <= dq_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + 6'd1;
          if (step_r == 6'd63) begin
            mean_r  <= dq_nxt[31:0];
            issue_r <= '0;
            acc_r   <= '0;
            state_r <= L_WALK;
          end
        end
        L_WALK: begin
          if (issuing) begin
            issue_r <= issue_r + CW'(1);
          end else if (!v1_r && !v2_r && !v3_r) begin
            dq_r    <= acc_r;
            rem_r   <= '0;
            div_r   <= n - CW'(1);
            step_r  <= '0;
            state_r <= L_VAR;
          end
        end
        L_VAR: begin
          dq_r   <= dq_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + 6'd1;
          if (step_r == 6'd63) begin
            // Variance is clipped to 56 bits before the scale by 256.
            sv_r    <= (|dq_nxt[63:56]) ? {{56{1'b1}}, 8'b0} : {dq_nxt[55:0], 8'b0};
            root_r  <= '0;
            srem_r  <= '0;
            step_r  <= '0;
            state_r <= L_SQRT;
          end
        end
        L_SQRT: begin
          sv_r   <= {sv_r[61:0], 2'b00};
          srem_r <= srem_nxt;
          root_r <= root_nxt;
          step_r <= step_r + 6'd1;
          if (step_r == 6'd31) begin
            stdev_r <= root_nxt;
            state_r <= L_LIM;
          end
        end
        L_LIM: begin
          limit_r <= (|lim_sum[36:36]) ? LIMIT_MAX : lim_sum[35:8];
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign idle  = (state_r == L_IDLE);
  assign limit = limit_r;
endmodule
`default_nettype wire

[sv/calibrated_leak_threshold_monitor.sv]
// ---------------------------------------------------------------------------
// calibrated_leak_threshold_monitor: peak plus k sigma plus margin leak detector
// Calibrates per-channel limits from the first pairs, then watches.
// ---------------------------------------------------------------------------
// Each accepted beat returns one result beat. Calibration and watching beats
// return their result from a register in the cycle after acceptance. The beat
// that completes calibration starts both channel lanes, which run in parallel:
// a load step, a 64-step serial divide for the mean, a walk over the stored
// samples, a 64-step divide for the variance, a 32-step square root and a
// limit step; when a single pair calibrates they skip from the load step to
// the limit step. Its result is reported once both lanes are done, and no
// input beat is taken meanwhile. The first pair over a limit halts the block
// until reset. No clearing pass after reset.
`default_nettype none
module calibrated_leak_threshold_monitor import clt_pkg::*; #(
  parameter int MAX_SAMPLES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SAMPLE_W-1:0]   in_virtual_kb,
  input  wire logic [SAMPLE_W-1:0]   in_resident_kb,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PHASE_W-1:0]         out_phase,
  output logic                       out_virtual_over,
  output logic                       out_resident_over,
  output logic [LIMIT_W-1:0]         out_virtual_threshold,
  output logic [LIMIT_W-1:0]         out_resident_threshold,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = $clog2(MAX_SAMPLES);

  logic [CCOUNT_W-1:0] cal_count_r;
  logic [MULT_W-1:0]   dev_mult_r;
  logic [MARGIN_W-1:0] v_margin_r, r_margin_r;
  logic [PHASE_W-1:0]  phase_r;
  logic [CW-1:0]       cnt_r, cnt_inc, n_eff;
  logic                busy_r, in_acc, completing, v_over, r_over;
  logic                v_idle, r_idle;
  logic [LIMIT_W-1:0]  v_lim, r_lim;
  clt_ctrl_t           ctrl;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy_r && (!out_valid || out_ready);
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    if (cal_count_r == '0) n_eff = CW'(1);
    else if (32'(cal_count_r) > MAX_SAMPLES) n_eff = CW'(MAX_SAMPLES);
    else n_eff = CW'(cal_count_r);
    cnt_inc = (32'(cnt_r) < MAX_SAMPLES) ? cnt_r + CW'(1) : cnt_r;
    completing = cnt_inc >= n_eff;
    ctrl.wr    = in_acc && (phase_r == PHASE_CAL) && (32'(cnt_r) < MAX_SAMPLES);
    ctrl.start = in_acc && (phase_r == PHASE_CAL) && completing;
    v_over = in_virtual_kb > v_lim;
    r_over = in_resident_kb > r_lim;
  end

  clt_lane #(.MAX_SAMPLES(MAX_SAMPLES)) u_v_lane (
    .clk, .rst_n, .ctrl, .sample(in_virtual_kb), .wr_idx(cnt_r[AW-1:0]), .n(cnt_r),
    .mult(dev_mult_r), .margin(v_margin_r), .idle(v_idle), .limit(v_lim)
  );
  clt_lane #(.MAX_SAMPLES(MAX_SAMPLES)) u_r_lane (
    .clk, .rst_n, .ctrl, .sample(in_resident_kb), .wr_idx(cnt_r[AW-1:0]), .n(cnt_r),
    .mult(dev_mult_r), .margin(r_margin_r), .idle(r_idle), .limit(r_lim)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_count_r <= CAL_COUNT_RST;
      dev_mult_r  <= DEV_MULT_RST;
      v_margin_r  <= V_MARGIN_RST;
      r_margin_r  <= R_MARGIN_RST;
      phase_r     <= PHASE_CAL;
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_CAL_COUNT: cal_count_r <= cfg_data[CCOUNT_W-1:0];
          REG_DEV_MULT:  dev_mult_r  <= cfg_data[MULT_W-1:0];
          REG_V_MARGIN:  v_margin_r  <= cfg_data;
          REG_R_MARGIN:  r_margin_r  <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (busy_r && v_idle && r_idle) begin
        // Lanes finished: report the completing beat.
        busy_r                 <= 1'b0;
        out_valid              <= 1'b1;
        out_phase              <= phase_r;
        out_virtual_over       <= 1'b0;
        out_resident_over      <= 1'b0;
        out_virtual_threshold  <= v_lim;
        out_resident_threshold <= r_lim;
      end
      if (in_acc) begin
        out_virtual_over       <= 1'b0;
        out_resident_over      <= 1'b0;
        out_virtual_threshold  <= v_lim;
        out_resident_threshold <= r_lim;
        out_phase              <= phase_r;
        unique case (phase_r)
          PHASE_CAL: begin
            cnt_r <= cnt_inc;
            if (completing) begin
              phase_r <= PHASE_WATCH;
              busy_r  <= 1'b1;
            end else begin
              out_valid <= 1'b1;
            end
          end
          PHASE_WATCH: begin
            out_valid         <= 1'b1;
            out_virtual_over  <= v_over;
            out_resident_over <= r_over;
            if (v_over || r_over) begin
              phase_r   <= PHASE_HALT;
              out_phase <= PHASE_HALT;
            end
          end
          default: out_valid <= 1'b1;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

[sv/clt_checker.sv]
// ---------------------------------------------------------------------------
// clt_checker: port-level checks of the leak monitor
// Watches the result channel for consistent phase, flags and limits.
// ---------------------------------------------------------------------------
`default_nettype none
module clt_checker import clt_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [PHASE_W-1:0] out_phase,
  input wire logic               out_virtual_over,
  input wire logic               out_resident_over,
  input wire logic [LIMIT_W-1:0] out_virtual_threshold,
  input wire logic [LIMIT_W-1:0] out_resident_threshold
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phase)
      && $stable(out_virtual_threshold) && $stable(out_resident_threshold))
    else $error("result beat changed while stalled");

  a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == PHASE_CAL |->
      out_virtual_threshold == '0 && out_resident_threshold == '0)
    else $error("nonzero limit while calibrating");

  a_over_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_virtual_over || out_resident_over) |-> out_phase == PHASE_HALT)
    else $error("over flag without halt");

  a_no_phase3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_phase == PHASE_HALT |=>
      !out_valid || out_phase == PHASE_HALT)
    else $error("left halted phase");
endmodule

bind calibrated_leak_threshold_monitor clt_checker u_clt_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_phase, .out_virtual_over,
  .out_resident_over, .out_virtual_threshold, .out_resident_threshold
);
`default_nettype wire

[tb/tb_calibrated_leak_threshold_monitor.sv]
// ---------------------------------------------------------------------------
// tb_calibrated_leak_threshold_monitor: self-checking testbench
// Drives sample pairs and register writes into the monitor, predicts result
// beats from its own model of calibration, limits and watching or a fixed row,
// and compares each result field by field under several idling patterns.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_calibrated_leak_threshold_monitor;
  import clt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_LEN    = 60;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               v_over;
    logic               r_over;
    logic [LIMIT_W-1:0] v_thr;
    logic [LIMIT_W-1:0] r_thr;
  } verdict_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [SAMPLE_W-1:0]   v;
    logic [SAMPLE_W-1:0]   r;
    bit                    typed;
    verdict_t              want;
  } step_row_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_W-1:0] in_virtual_kb = '0;
  logic [SAMPLE_W-1:0] in_resident_kb = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PHASE_W-1:0] out_phase;
  logic out_virtual_over;
  logic out_resident_over;
  logic [LIMIT_W-1:0] out_virtual_threshold;
  logic [LIMIT_W-1:0] out_resident_threshold;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  calibrated_leak_threshold_monitor #(.MAX_SAMPLES(DEPTH)) i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_virtual_kb, .in_resident_kb,
    .out_valid, .out_ready, .out_phase, .out_virtual_over, .out_resident_over,
    .out_virtual_threshold, .out_resident_threshold,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model of the monitor's state and registers.
  logic [CCOUNT_W-1:0] m_count;
  logic [MULT_W-1:0]   m_mult;
  logic [MARGIN_W-1:0] m_v_margin;
  logic [MARGIN_W-1:0] m_r_margin;
  logic [SAMPLE_W-1:0] m_v_store [DEPTH];
  logic [SAMPLE_W-1:0] m_r_store [DEPTH];
  int unsigned         m_taken;
  logic [SAMPLE_W-1:0] m_v_peak;
  logic [SAMPLE_W-1:0] m_r_peak;
  logic [LIMIT_W-1:0]  m_v_limit;
  logic [LIMIT_W-1:0]  m_r_limit;
  logic [PHASE_W-1:0]  m_phase;

  verdict_t pending_verdicts[$];
  idle_mode_t idle_mode = IDLE_NONE;
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int hold_request = 0;
  bit saw_backpressure = 1'b0;

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [LIMIT_W-1:0] limit_for(bit resident, int unsigned n,
                                                   logic [SAMPLE_W-1:0] peak,
                                                   logic [MARGIN_W-1:0] margin);
    logic [63:0] stdev, sum, mean, acc, var_fx, s, d, lim;
    if (n < MIN_FOR_DEV) begin
      stdev = 64'(SINGLE_STDEV_FX);
    end else begin
      sum = '0;
      acc = '0;
      for (int i = 0; i < n; i++) sum += resident ? m_r_store[i] : m_v_store[i];
      mean = (sum << 8) / n;
      for (int i = 0; i < n; i++) begin
        s = 64'(resident ? m_r_store[i] : m_v_store[i]) << 8;
        d = (s >= mean) ? s - mean : mean - s;
        acc += (d * d) >> 8;
      end
      var_fx = acc / (n - 1);
      if (var_fx > (64'hFFFF_FFFF_FFFF_FFFF >> 8)) var_fx = 64'hFFFF_FFFF_FFFF_FFFF >> 8;
      stdev = isqrt(var_fx << 8);
    end
    lim = ((64'(peak) << 8) + 64'(m_mult) * stdev + (64'(margin) << 8)) >> 8;
    return (lim > 64'(LIMIT_MAX)) ? LIMIT_MAX : lim[LIMIT_W-1:0];
  endfunction

  function automatic verdict_t monitor_step(logic [SAMPLE_W-1:0] v, logic [SAMPLE_W-1:0] r);
    verdict_t res;
    int unsigned n;
    res = '0;
    if (m_phase == PHASE_CAL) begin
      n = m_count;
      if (n < 1) n = 1;
      if (n > DEPTH) n = DEPTH;
      if (m_taken < DEPTH) begin
        m_v_store[m_taken] = v;
        m_r_store[m_taken] = r;
        m_taken++;
      end
      if (v > m_v_peak) m_v_peak = v;
      if (r > m_r_peak) m_r_peak = r;
      if (m_taken >= n) begin
        m_v_limit = limit_for(1'b0, m_taken, m_v_peak, m_v_margin);
        m_r_limit = limit_for(1'b1, m_taken, m_r_peak, m_r_margin);
        m_phase = PHASE_WATCH;
      end
    end else if (m_phase == PHASE_WATCH) begin
      res.v_over = (28'(v) > m_v_limit);
      res.r_over = (28'(r) > m_r_limit);
      if (res.v_over || res.r_over) m_phase = PHASE_HALT;
    end
    res.phase = m_phase;
    res.v_thr = m_v_limit;
    res.r_thr = m_r_limit;
    return res;
  endfunction

  function automatic bit sender_idles();
    return (idle_mode == IDLE_SENDER) ? ($urandom_range(99) < 82) :
           (idle_mode == IDLE_BOTH)   ? ($urandom_range(99) < 17) : 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    return (idle_mode == IDLE_RECEIVER) ? ($urandom_range(99) < 82) :
           (idle_mode == IDLE_BOTH)     ? ($urandom_range(99) < 17) : 1'b0;
  endfunction

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(negedge clk) begin
    static int seen_request = 0;
    static int hold_left = 0;
    if (hold_request != seen_request) begin
      seen_request = hold_request;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && !receiver_stalls();
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_ready) saw_backpressure <= 1'b1;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result beat, phase %0d", $time, out_phase);
      end else begin
        verdict_t w;
        w = pending_verdicts.pop_front();
        check_field("phase", w.phase, out_phase);
        check_field("virtual_over", w.v_over, out_virtual_over);
        check_field("resident_over", w.r_over, out_resident_over);
        check_field("virtual_threshold", w.v_thr, out_virtual_threshold);
        check_field("resident_threshold", w.r_thr, out_resident_threshold);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_verdicts.size());
      $display("calibrated_leak_threshold_monitor test failed");
      $finish;
    end
  end

  // Called and returns at a falling edge.
  task automatic send_pair(logic [SAMPLE_W-1:0] v, logic [SAMPLE_W-1:0] r,
                           bit typed = 1'b0, verdict_t want = '0);
    verdict_t predicted;
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_virtual_kb <= v;
    in_resident_kb <= r;
    do @(posedge clk); while (!in_ready);
    predicted = monitor_step(v, r);
    pending_verdicts.push_back(typed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CAL_COUNT: m_count = data[CCOUNT_W-1:0];
      REG_DEV_MULT:  m_mult = data[MULT_W-1:0];
      REG_V_MARGIN:  m_v_margin = data[MARGIN_W-1:0];
      REG_R_MARGIN:  m_r_margin = data[MARGIN_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic step_row_t pair_row(logic [SAMPLE_W-1:0] v, logic [SAMPLE_W-1:0] r,
                                         bit typed = 1'b0);
    step_row_t row;
    row = '{default: '0};
    row.v = v;
    row.r = r;
    row.typed = typed;
    row.want.phase = PHASE_CAL;
    return row;
  endfunction

  function automatic step_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    step_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic logic [SAMPLE_W-1:0] safe_sample(logic [LIMIT_W-1:0] lim);
    case ($urandom_range(3))
      0: return SAMPLE_W'(lim);
      1: return SAMPLE_W'(lim - $urandom_range(3));
      2: return SAMPLE_W'($urandom) & SAMPLE_W'(lim);
      default: return SAMPLE_W'($urandom_range(lim));
    endcase
  endfunction

  initial begin
    step_row_t plan[$];
    m_count = CAL_COUNT_RST;
    m_mult = DEV_MULT_RST;
    m_v_margin = V_MARGIN_RST;
    m_r_margin = R_MARGIN_RST;
    m_taken = 0;
    m_v_peak = '0;
    m_r_peak = '0;
    m_v_limit = '0;
    m_r_limit = '0;
    m_phase = PHASE_CAL;

    // Calibration beats read zero limits. Lowering the count to zero mid-way
    // ends calibration on the next pair with all four stored pairs.
    plan.push_back(pair_row(24'd0, 24'd0, 1'b1));
    plan.push_back(reg_row(REG_CAL_COUNT, 20'd31));
    plan.push_back(reg_row(REG_DEV_MULT, 20'd0));
    plan.push_back(reg_row(REG_V_MARGIN, 20'd0));
    plan.push_back(reg_row(REG_R_MARGIN, 20'hFFFFF));
    plan.push_back(pair_row(24'd1000, 24'd200, 1'b1));
    plan.push_back(pair_row(24'd3000, 24'd50, 1'b1));
    plan.push_back(reg_row(REG_DEV_MULT, 20'd15));
    plan.push_back(reg_row(REG_V_MARGIN, 20'hFFFFF));
    plan.push_back(reg_row(REG_R_MARGIN, 20'd0));
    plan.push_back(reg_row(REG_CAL_COUNT, 20'd0));
    plan.push_back(pair_row(24'd2000, 24'd400));
    plan.push_back(pair_row(24'd0, 24'd0));
    plan.push_back(pair_row(24'd3000, 24'd400));
    // Limits must hold across register writes once watching.
    plan.push_back(reg_row(REG_CAL_COUNT, 20'd16));
    plan.push_back(reg_row(REG_DEV_MULT, 20'd4));
    plan.push_back(pair_row(24'd2999, 24'd399));
    plan.push_back(pair_row(24'd1, 24'd1));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
      else send_pair(plan[i].v, plan[i].r, plan[i].typed, plan[i].want);
    end

    for (int mode = IDLE_NONE; mode <= IDLE_BOTH; mode++) begin
      drain();
      write_reg(CFG_IDX_W'($urandom_range(3)),
                $urandom_range(1) ? CFG_DATA_W'($urandom) : '0);
      idle_mode = idle_mode_t'(mode);
      if (mode == IDLE_NONE) begin
        @(posedge clk);
        hold_request++;
        @(negedge clk);
      end
      repeat (310) send_pair(safe_sample(m_v_limit), safe_sample(m_r_limit));
    end

    // Trip the monitor, then keep feeding it full-range pairs while halted.
    idle_mode = IDLE_BOTH;
    case ($urandom_range(2))
      0: send_pair(SAMPLE_W'(m_v_limit + 1), safe_sample(m_r_limit));
      1: send_pair(safe_sample(m_v_limit), SAMPLE_W'(m_r_limit + 1));
      default: send_pair(SAMPLE_W'(m_v_limit + 1 + $urandom_range(9)),
                         SAMPLE_W'(m_r_limit + 1 + $urandom_range(9)));
    endcase
    send_pair('1, '1);
    send_pair('0, '1);
    repeat (40) send_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom));

    drain();
    repeat (20) @(negedge clk);
    $display("covered %0d sample pairs, %0d register writes, %0d result beats",
             items_sent, cfg_writes, results_seen);
    $display("calibration, watching under four idling patterns, input backpressure %0s, halt",
             saw_backpressure ? "seen" : "not seen");
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("calibrated_leak_threshold_monitor test passed");
    end else begin
      $display("calibrated_leak_threshold_monitor test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
